@@ hw/rtl/ip6acl_pkg.sv @@
// ----------------------------------------------------------------------------
// ip6acl_pkg
// shared types and constants of the first-match ipv6 prefix acl
// ----------------------------------------------------------------------------
package ip6acl_pkg;

  // rule table geometry
  localparam int RULES   = 16;
  localparam int SLOT_W  = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CNT_W   = $clog2(RULES + 1);

  // fixed field widths
  localparam int HALF_W    = 64;
  localparam int ADDR_W    = 2 * HALF_W;
  localparam int PREFIX_W  = 8;
  localparam int INDEX_W   = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  localparam logic [PREFIX_W-1:0] MAX_PREFIX = PREFIX_W'(ADDR_W);

  // request kinds
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ALLOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT    = CFG_IDX_W'(1);

  typedef struct packed {
    logic                req_type;
    logic                is_ipv6;
    logic [HALF_W-1:0]   addr_high;
    logic [HALF_W-1:0]   addr_low;
    logic [INDEX_W-1:0]  rule_index;
    logic [PREFIX_W-1:0] prefix_length;
    logic                rule_allow;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic               matched;
    logic [INDEX_W-1:0] match_slot;
  } resp_t;

  typedef struct packed {
    logic [HALF_W-1:0]   net_high;
    logic [HALF_W-1:0]   net_low;
    logic [PREFIX_W-1:0] prefix;
    logic                verdict;
  } rule_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/ipv6_first_match_acl.sv @@
// ----------------------------------------------------------------------------
// ipv6_first_match_acl
// first-match access control over a table of ipv6 prefix rules
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_stall / in_data): each word is either a rule
//   write (req_type = 1) that stores network, prefix length and verdict in a
//   table slot and gives no result, or a lookup (req_type = 0) that gives
//   exactly one word on the out channel (out_valid / out_stall / out_data).
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   default_allow, index 1 is rule_count; other indexes are dropped. ready
//   is always high; write only while the block is idle.
//   a rule write keeps the block idle. a lookup holds in_stall high
//   until its result is handed to the output register. the scan reads one
//   table entry per cycle through a single registered read port and one
//   shared 128-bit masked compare and stops at the first hit, or after
//   n = min(rule_count, 16) rules on a miss. non-ipv6 lookups and an empty
//   rule set skip the scan.
//   the output register lets the next word be accepted while a result waits
//   on out_stall; a finished lookup waits in ST_DONE until the register frees.
//   reset (rst, synchronous) clears the configuration and control state; the
//   rule table itself is not cleared and must be written before it is used.
// ----------------------------------------------------------------------------
module ipv6_first_match_acl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ip6acl_pkg::req_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ip6acl_pkg::resp_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ip6acl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ip6acl_pkg::CFG_DAT_W-1:0]  cfg_data
);

  // configuration registers
  logic                               default_allow;
  logic [ip6acl_pkg::COUNT_W-1:0]     rule_count;
  logic [ip6acl_pkg::CNT_W-1:0]       limit;

  // sequencer
  ip6acl_pkg::state_t                 state, state_next;
  logic [ip6acl_pkg::CNT_W-1:0]       idx, idx_next;
  ip6acl_pkg::resp_t                  res, res_next;
  logic                               issue;
  logic                               load_out;

  // lookup address held for the scan
  logic [ip6acl_pkg::ADDR_W-1:0]      addr;

  // rule table with registered read port
  ip6acl_pkg::rule_t                  table_mem [ip6acl_pkg::RULES];
  ip6acl_pkg::rule_t                  rd_data;
  logic                               rd_valid, rd_valid_next;
  logic [ip6acl_pkg::SLOT_W-1:0]      rd_slot;

  // shared compare unit
  logic [ip6acl_pkg::ADDR_W-1:0]      mask;
  logic                               hit;

  logic                               in_acc;
  logic                               wr_ok;
  ip6acl_pkg::rule_t                  wr_rule;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  // a count above the table size scans the whole table
  assign limit = (32'(rule_count) > ip6acl_pkg::RULES) ?
                 ip6acl_pkg::CNT_W'(ip6acl_pkg::RULES) :
                 ip6acl_pkg::CNT_W'(rule_count);

  // writes beyond the table are dropped
  assign wr_ok = 32'(in_data.rule_index) < ip6acl_pkg::RULES;

  always_comb begin
    wr_rule.net_high = in_data.addr_high;
    wr_rule.net_low  = in_data.addr_low;
    // over-long prefixes compare every bit
    wr_rule.prefix   = (in_data.prefix_length > ip6acl_pkg::MAX_PREFIX) ?
                       ip6acl_pkg::MAX_PREFIX : in_data.prefix_length;
    wr_rule.verdict  = in_data.rule_allow;
  end

  // top prefix bits set; zero prefix gives an empty mask
  assign mask = ~({ip6acl_pkg::ADDR_W{1'b1}} >> rd_data.prefix);
  assign hit  = rd_valid &&
                (((addr ^ {rd_data.net_high, rd_data.net_low}) & mask) == '0);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      default_allow <= 1'b0;
      rule_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ip6acl_pkg::CFG_DEFAULT_ALLOW: default_allow <= cfg_data[0];
        ip6acl_pkg::CFG_RULE_COUNT:    rule_count    <= ip6acl_pkg::COUNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // next state and control
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    res_next      = res;
    issue         = 1'b0;
    rd_valid_next = 1'b0;
    load_out      = 1'b0;
    in_stall      = 1'b1;
    unique case (state)
      ip6acl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc && in_data.req_type == ip6acl_pkg::REQ_LOOKUP) begin
          res_next.allowed    = default_allow;
          res_next.matched    = 1'b0;
          res_next.match_slot = '0;
          idx_next            = '0;
          if (in_data.is_ipv6 && limit != '0) begin
            state_next = ip6acl_pkg::ST_SCAN;
          end else begin
            state_next = ip6acl_pkg::ST_DONE;
          end
        end
      end
      ip6acl_pkg::ST_SCAN: begin
        // fetch the next rule while the previous one is compared
        issue = idx < limit;
        if (issue) begin
          idx_next = idx + 1'b1;
        end
        if (hit) begin
          res_next.allowed    = rd_data.verdict;
          res_next.matched    = 1'b1;
          res_next.match_slot = ip6acl_pkg::INDEX_W'(rd_slot);
          state_next          = ip6acl_pkg::ST_DONE;
        end else begin
          rd_valid_next = issue;
          if (!issue) begin
            state_next = ip6acl_pkg::ST_DONE;
          end
        end
      end
      ip6acl_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ip6acl_pkg::ST_IDLE;
        end
      end
      default: state_next = ip6acl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ip6acl_pkg::ST_IDLE;
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      rd_valid <= rd_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res <= res_next;
    if (in_acc) begin
      addr <= {in_data.addr_high, in_data.addr_low};
    end
  end

  // rule table write and read ports
  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == ip6acl_pkg::REQ_WRITE && wr_ok) begin
      table_mem[ip6acl_pkg::SLOT_W'(in_data.rule_index)] <= wr_rule;
    end
    if (issue) begin
      rd_data <= table_mem[idx[ip6acl_pkg::SLOT_W-1:0]];
      rd_slot <= idx[ip6acl_pkg::SLOT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

  // checks
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.req_type == ip6acl_pkg::REQ_LOOKUP)
    |=> (state != ip6acl_pkg::ST_IDLE))
    else $error("lookup accepted without starting");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ip6acl_pkg::ST_SCAN) |-> (idx <= limit))
    else $error("scan index beyond rule count");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ip6acl_pkg::ST_SCAN && rd_valid) |-> (32'(rd_slot) < 32'(limit)))
    else $error("rule read beyond rule count");

  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.matched) |-> (out_data.match_slot == '0))
    else $error("slot reported without a match");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting word");

endmodule
